// ----- hdl/vrtp_pkg.sv -----
// Shared constants and types of the vertex rotate, translate and project block.
package vrtp_pkg;

   localparam int ANGLE_BITS_DEFAULT = 12;
   localparam int COORD_BITS_DEFAULT = 16;

   // Q2.30 angle and series constants
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
   localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
   localparam logic [15:0] Q14_ONE     = 16'd16384;
   localparam int          Q14_SHIFT   = 14;

   // Taylor series of the sine, innermost term first
   localparam int NUM_TERMS = 5;
   localparam logic [6:0] TERM_DIV [NUM_TERMS] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
   localparam logic [31:0] TERM_RECIP [NUM_TERMS] = '{
      32'((64'd1 << 32) / 64'd110),
      32'((64'd1 << 32) / 64'd72),
      32'((64'd1 << 32) / 64'd42),
      32'((64'd1 << 32) / 64'd20),
      32'((64'd1 << 32) / 64'd6)
   };

   // register map, word index
   localparam logic [1:0] REG_OFFSET_X = 2'd0;
   localparam logic [1:0] REG_OFFSET_Y = 2'd1;
   localparam logic [1:0] REG_OFFSET_Z = 2'd2;
   localparam logic [1:0] REG_FOCAL    = 2'd3;

   localparam logic signed [15:0] OFFSET_X_RESET = 16'sd1000;
   localparam logic signed [15:0] OFFSET_Y_RESET = 16'sd1000;
   localparam logic signed [15:0] OFFSET_Z_RESET = 16'sd4000;
   localparam logic [14:0]        FOCAL_RESET    = 15'd1000;

   // one lane of the sine series pipeline
   typedef struct packed {
      logic [30:0] x;
      logic [31:0] x2;
      logic [30:0] t;
      logic [31:0] m;
      logic [31:0] q0;
      logic        neg;
   } trig_lane_type;

endpackage

// ----- hdl/vertex_rotate_translate_project.sv -----
// Top level: pipelined vertex rotation about Y, translation and perspective projection.
//
// Takes one vertex per clock on the req_ stream whenever req_tready is high, that is while
// the skid buffer is empty, and returns one beat per vertex on the rsp_ stream, in order.
// Sine and cosine of the phase are evaluated per vertex by a 20-stage series
// pipeline (two lanes), the rotation and offsets take two stages, the scaling by the focal
// distance one, and each projected coordinate is divided by the translated depth in a
// restoring divider of COORD_BITS+1 stages, one quotient bit per stage, plus an overflow
// stage that drives saturation. An output register with a one-beat skid buffer separates
// the two streams, so req_tready depends only on the skid occupancy and a full pipeline
// keeps moving while one finished beat waits. A depth of zero or less returns zeros with
// depth_invalid set; a quotient outside the signed coordinate range is clamped and flagged
// as clipped. Registers (offsets and focal distance) sit on the csr_ port at word addresses
// 0, 4, 8 and 12; write them only while the stream is idle.
module vertex_rotate_translate_project #(
   parameter int ANGLE_BITS = vrtp_pkg::ANGLE_BITS_DEFAULT,
   parameter int COORD_BITS = vrtp_pkg::COORD_BITS_DEFAULT,
   localparam int REQ_W = ((3 * COORD_BITS + ANGLE_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // vertex_x, vertex_y, vertex_z, angle_phase
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // proj_x, proj_y
   output logic [1:0]       rsp_tuser,   // depth_invalid, clipped
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [3:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int AB = ANGLE_BITS;
   localparam int CW = COORD_BITS;
   localparam int EW = (CW > 16) ? CW : 16;
   localparam int PW = CW + 16;             // trig times coordinate
   localparam int TW = EW + 17;             // translated coordinate, scaled by 2^14
   localparam int DW = TW - 1;              // positive depth
   localparam int NW = TW + 15;             // magnitude times focal distance
   localparam int QB = CW + 1;              // quotient bits before saturation
   localparam int CMPW = TW + CW + 15;
   localparam int TRIG_STAGES = 3 + 3 * vrtp_pkg::NUM_TERMS + 2;
   localparam logic [AB-2:0] QUARTER = (AB-1)'(1) << (AB - 2);
   localparam logic [QB-1:0] LIM_Q = QB'(1) << (CW - 1);

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
   } vertex_type;

   typedef struct packed {
      logic [NW-1:0] rem_x;
      logic [NW-1:0] rem_y;
      logic [QB-1:0] q_x;
      logic [QB-1:0] q_y;
      logic          neg_x;
      logic          neg_y;
      logic          ovf_x;
      logic          ovf_y;
      logic [DW-1:0] d;
      logic          dinv;
   } div_type;

   typedef struct packed {
      logic signed [CW-1:0] px;
      logic signed [CW-1:0] py;
      logic                 dinv;
      logic                 clip;
   } result_type;

   // fold a phase into the first quarter wave
   function automatic logic [AB-2:0] fold_k(input logic [AB-1:0] p);
      logic [AB-2:0] off;
      off = {1'b0, p[AB-3:0]};
      if (p[AB-2]) begin
         return QUARTER - off;
      end
      return off;
   endfunction

   // {clip, value}
   function automatic logic [CW:0] clamp(input logic [QB-1:0] qm, input logic neg,
                                         input logic ovf);
      logic [CW-1:0] mag;
      mag = qm[CW-1:0];
      if (!neg) begin
         if (ovf || qm >= LIM_Q) begin
            return {1'b1, 1'b0, {(CW-1){1'b1}}};
         end
         return {1'b0, mag};
      end
      if (ovf || qm > LIM_Q) begin
         return {1'b1, 1'b1, {(CW-1){1'b0}}};
      end
      return {1'b0, CW'(-mag)};
   endfunction

   // ---------------------------------------------------------------- registers
   logic signed [15:0] offset_x_ff, offset_y_ff, offset_z_ff;
   logic [14:0]        focal_ff;
   logic               csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_x_ff <= vrtp_pkg::OFFSET_X_RESET;
         offset_y_ff <= vrtp_pkg::OFFSET_Y_RESET;
         offset_z_ff <= vrtp_pkg::OFFSET_Z_RESET;
         focal_ff    <= vrtp_pkg::FOCAL_RESET;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            vrtp_pkg::REG_OFFSET_X: offset_x_ff <= csr_pwdata[15:0];
            vrtp_pkg::REG_OFFSET_Y: offset_y_ff <= csr_pwdata[15:0];
            vrtp_pkg::REG_OFFSET_Z: offset_z_ff <= csr_pwdata[15:0];
            vrtp_pkg::REG_FOCAL:    focal_ff    <= csr_pwdata[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         vrtp_pkg::REG_OFFSET_X: csr_prdata = {16'd0, offset_x_ff};
         vrtp_pkg::REG_OFFSET_Y: csr_prdata = {16'd0, offset_y_ff};
         vrtp_pkg::REG_OFFSET_Z: csr_prdata = {16'd0, offset_z_ff};
         vrtp_pkg::REG_FOCAL:    csr_prdata = {17'd0, focal_ff};
         default:                csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- flow control
   logic adv;            // whole pipeline moves one stage
   logic skid_v_ff, out_v_ff;

   assign adv        = !skid_v_ff;
   assign req_tready = adv;

   // ---------------------------------------------------------------- sine/cosine
   // lane 0 is the sine, lane 1 the cosine (phase plus a quarter turn)
   logic [TRIG_STAGES-1:0]  vld_ff;
   vertex_type              vtx_ff  [TRIG_STAGES];
   vertex_type              vtx_in;
   vrtp_pkg::trig_lane_type lane_in [TRIG_STAGES-1][2];
   vrtp_pkg::trig_lane_type lane_ff [TRIG_STAGES-1][2];
   logic signed [15:0]      trig_in [2];
   logic signed [15:0]      trig_ff [2];
   logic [AB-1:0]           phase_in [2];

   always_comb begin
      vtx_in.x    = req_tdata[CW-1:0];
      vtx_in.y    = req_tdata[2*CW-1:CW];
      vtx_in.z    = req_tdata[3*CW-1:2*CW];
      phase_in[0] = req_tdata[3*CW+AB-1:3*CW];
      phase_in[1] = phase_in[0] + AB'(QUARTER);
      for (int l = 0; l < 2; l++) begin
         lane_in[0][l]     = '0;
         lane_in[0][l].x   = 31'(fold_k(phase_in[l]));
         lane_in[0][l].neg = phase_in[l][AB-1];
      end
   end

   for (genvar g = 1; g < TRIG_STAGES - 1; g++) begin : g_trig
      localparam int TERM = (g - 3) / 3;
      localparam int PH   = (g - 3) % 3;
      if (g == 1) begin : g_angle
         // x = k * pi/2 in Q2.30
         always_comb begin
            logic [AB+29:0] prod;
            for (int l = 0; l < 2; l++) begin
               prod = (AB+30)'(lane_ff[g-1][l].x[AB-2:0]) * (AB+30)'(vrtp_pkg::HALF_PI_Q30);
               lane_in[g][l]   = lane_ff[g-1][l];
               lane_in[g][l].x = prod[AB+28:AB-2];
            end
         end
      end else if (g == 2) begin : g_square
         always_comb begin
            logic [61:0] prod;
            for (int l = 0; l < 2; l++) begin
               prod = 62'(lane_ff[g-1][l].x) * 62'(lane_ff[g-1][l].x);
               lane_in[g][l]    = lane_ff[g-1][l];
               lane_in[g][l].x2 = prod[61:30];
               lane_in[g][l].t  = vrtp_pkg::Q30_ONE;
            end
         end
      end else if (g == TRIG_STAGES - 2) begin : g_final
         always_comb begin
            logic [61:0] prod;
            for (int l = 0; l < 2; l++) begin
               prod = 62'(lane_ff[g-1][l].x) * 62'(lane_ff[g-1][l].t);
               lane_in[g][l]   = lane_ff[g-1][l];
               lane_in[g][l].x = prod[60:30];
            end
         end
      end else if (PH == 0) begin : g_mul
         // m = x^2 * t
         always_comb begin
            logic [62:0] prod;
            for (int l = 0; l < 2; l++) begin
               prod = 63'(lane_ff[g-1][l].x2) * 63'(lane_ff[g-1][l].t);
               lane_in[g][l]   = lane_ff[g-1][l];
               lane_in[g][l].m = prod[61:30];
            end
         end
      end else if (PH == 1) begin : g_recip
         // estimate m / d by the reciprocal, low by at most one
         always_comb begin
            logic [63:0] prod;
            for (int l = 0; l < 2; l++) begin
               prod = 64'(lane_ff[g-1][l].m) * 64'(vrtp_pkg::TERM_RECIP[TERM]);
               lane_in[g][l]    = lane_ff[g-1][l];
               lane_in[g][l].q0 = prod[63:32];
            end
         end
      end else begin : g_fix
         // correct the estimate, then t = 1 - m / d
         always_comb begin
            logic [31:0] rem;
            logic [31:0] quo;
            for (int l = 0; l < 2; l++) begin
               rem = lane_ff[g-1][l].m
                     - 32'(lane_ff[g-1][l].q0 * 32'(vrtp_pkg::TERM_DIV[TERM]));
               quo = lane_ff[g-1][l].q0 + 32'(rem >= 32'(vrtp_pkg::TERM_DIV[TERM]));
               lane_in[g][l]   = lane_ff[g-1][l];
               lane_in[g][l].t = vrtp_pkg::Q30_ONE - quo[30:0];
            end
         end
      end
   end

   // round to Q1.14, cap at one, apply the quadrant sign
   always_comb begin
      logic [31:0] rnd;
      logic [15:0] mag;
      for (int l = 0; l < 2; l++) begin
         rnd = 32'(lane_ff[TRIG_STAGES-2][l].x) + 32'h0000_8000;
         mag = (rnd[31:16] > vrtp_pkg::Q14_ONE) ? vrtp_pkg::Q14_ONE : rnd[31:16];
         trig_in[l] = lane_ff[TRIG_STAGES-2][l].neg ? -$signed(mag) : $signed(mag);
      end
   end

   // ---------------------------------------------------------------- rotate, translate
   logic signed [PW-1:0]   pcx_ff, psz_ff, psx_ff, pcz_ff;
   logic signed [EW:0]     ysum_ff;
   logic                   g_v_ff;
   logic signed [TW-1:0]   tx_ff, ty_ff, tz_ff;
   logic                   h_v_ff;
   logic [NW-1:0]          numx_ff, numy_ff;
   logic                   negx_ff, negy_ff, dinv_ff;
   logic [DW-1:0]          d_ff;
   logic                   i_v_ff;
   logic signed [TW-1:0]   tx_in, ty_in, tz_in;
   logic [TW-1:0]          ax_in, ay_in;
   div_type                div_in [QB+1];
   div_type                div_ff [QB+1];
   logic [QB:0]            div_v_ff;

   always_comb begin
      tx_in = TW'(pcx_ff) + TW'(psz_ff) + (TW'(offset_x_ff) <<< vrtp_pkg::Q14_SHIFT);
      ty_in = TW'(ysum_ff) <<< vrtp_pkg::Q14_SHIFT;
      tz_in = TW'(pcz_ff) - TW'(psx_ff) + (TW'(offset_z_ff) <<< vrtp_pkg::Q14_SHIFT);
      ax_in = tx_ff[TW-1] ? TW'(-tx_ff) : TW'(tx_ff);
      ay_in = ty_ff[TW-1] ? TW'(-ty_ff) : TW'(ty_ff);
   end

   // overflow check ahead of the divider
   always_comb begin
      div_in[0]       = '0;
      div_in[0].rem_x = numx_ff;
      div_in[0].rem_y = numy_ff;
      div_in[0].neg_x = negx_ff;
      div_in[0].neg_y = negy_ff;
      div_in[0].d     = d_ff;
      div_in[0].dinv  = dinv_ff;
      div_in[0].ovf_x = CMPW'(numx_ff) >= (CMPW'(d_ff) << QB);
      div_in[0].ovf_y = CMPW'(numy_ff) >= (CMPW'(d_ff) << QB);
   end

   // restoring division, most significant quotient bit first
   for (genvar s = 0; s < QB; s++) begin : g_div
      localparam int BIT = QB - 1 - s;
      always_comb begin
         logic [CMPW-1:0] dsh;
         dsh = CMPW'(div_ff[s].d) << BIT;
         div_in[s+1] = div_ff[s];
         if (CMPW'(div_ff[s].rem_x) >= dsh) begin
            div_in[s+1].rem_x    = div_ff[s].rem_x - dsh[NW-1:0];
            div_in[s+1].q_x[BIT] = 1'b1;
         end
         if (CMPW'(div_ff[s].rem_y) >= dsh) begin
            div_in[s+1].rem_y    = div_ff[s].rem_y - dsh[NW-1:0];
            div_in[s+1].q_y[BIT] = 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- saturate, output
   result_type fin, out_ff, skid_ff;
   logic       fin_v, rsp_take;
   logic [CW:0] sat_x, sat_y;

   always_comb begin
      sat_x = clamp(div_ff[QB].q_x, div_ff[QB].neg_x, div_ff[QB].ovf_x);
      sat_y = clamp(div_ff[QB].q_y, div_ff[QB].neg_y, div_ff[QB].ovf_y);
      fin.dinv = div_ff[QB].dinv;
      if (div_ff[QB].dinv) begin
         fin.px   = '0;
         fin.py   = '0;
         fin.clip = 1'b0;
      end else begin
         fin.px   = sat_x[CW-1:0];
         fin.py   = sat_y[CW-1:0];
         fin.clip = sat_x[CW] || sat_y[CW];
      end
   end

   assign fin_v    = div_v_ff[QB] && adv;
   assign rsp_take = out_v_ff && rsp_tready;

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = RSP_W'({out_ff.py, out_ff.px});
   assign rsp_tuser  = {out_ff.clip, out_ff.dinv};

   // ---------------------------------------------------------------- state
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         g_v_ff    <= 1'b0;
         h_v_ff    <= 1'b0;
         i_v_ff    <= 1'b0;
         div_v_ff  <= '0;
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (adv) begin
            vld_ff   <= {vld_ff[TRIG_STAGES-2:0], req_tvalid};
            g_v_ff   <= vld_ff[TRIG_STAGES-1];
            h_v_ff   <= g_v_ff;
            i_v_ff   <= h_v_ff;
            div_v_ff <= {div_v_ff[QB-1:0], i_v_ff};
         end
         // drain the skid first, else take the pipeline head
         if (!out_v_ff || rsp_take) begin
            if (skid_v_ff) begin
               out_v_ff  <= 1'b1;
               skid_v_ff <= 1'b0;
            end else begin
               out_v_ff <= fin_v;
            end
         end else if (fin_v) begin
            skid_v_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         vtx_ff[0] <= vtx_in;
         for (int i = 1; i < TRIG_STAGES; i++) begin
            vtx_ff[i] <= vtx_ff[i-1];
         end
         for (int g = 0; g < TRIG_STAGES - 1; g++) begin
            lane_ff[g] <= lane_in[g];
         end
         trig_ff <= trig_in;
         // rotate about Y: lane 0 sine, lane 1 cosine
         pcx_ff  <= PW'(trig_ff[1]) * PW'(vtx_ff[TRIG_STAGES-1].x);
         psz_ff  <= PW'(trig_ff[0]) * PW'(vtx_ff[TRIG_STAGES-1].z);
         psx_ff  <= PW'(trig_ff[0]) * PW'(vtx_ff[TRIG_STAGES-1].x);
         pcz_ff  <= PW'(trig_ff[1]) * PW'(vtx_ff[TRIG_STAGES-1].z);
         ysum_ff <= (EW+1)'(vtx_ff[TRIG_STAGES-1].y) + (EW+1)'(offset_y_ff);
         tx_ff   <= tx_in;
         ty_ff   <= ty_in;
         tz_ff   <= tz_in;
         numx_ff <= NW'(ax_in) * NW'(focal_ff);
         numy_ff <= NW'(ay_in) * NW'(focal_ff);
         negx_ff <= tx_ff[TW-1];
         negy_ff <= ty_ff[TW-1];
         d_ff    <= tz_ff[DW-1:0];
         dinv_ff <= tz_ff[TW-1] || (tz_ff == '0);
         for (int s = 0; s <= QB; s++) begin
            div_ff[s] <= div_in[s];
         end
      end
      if (!out_v_ff || rsp_take) begin
         out_ff <= skid_v_ff ? skid_ff : fin;
      end else if (fin_v) begin
         skid_ff <= fin;
      end
   end

   // ---------------------------------------------------------------- checks
   a_skid_has_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid holds a beat while the output register is empty");

   a_skid_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(out_v_ff && !rsp_tready))
      else $error("skid filled without an output stall");

   a_depth_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata[2*CW-1:0] == '0 && !rsp_tuser[1]))
      else $error("invalid depth beat carries data or clip");

   a_trig_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[TRIG_STAGES-1] |-> (trig_ff[0] >= -16'sd16384 && trig_ff[0] <= 16'sd16384
                                 && trig_ff[1] >= -16'sd16384 && trig_ff[1] <= 16'sd16384))
      else $error("sine or cosine outside one");

   a_clip_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |->
         (out_ff.px == {1'b0, {(CW-1){1'b1}}} || out_ff.px == {1'b1, {(CW-1){1'b0}}}
          || out_ff.py == {1'b0, {(CW-1){1'b1}}} || out_ff.py == {1'b1, {(CW-1){1'b0}}}))
      else $error("clipped beat with no coordinate at a bound");

endmodule
